>>> rtl/core/idla_pkg.sv
// Package for the direction lock arbiter: constants, codes and payload types.
// No dependencies.
`default_nettype none
package idla_pkg;
  localparam int TableSlots = 16;
  localparam int SlotW = $clog2(TableSlots);
  localparam int CntW = $clog2(TableSlots + 1);
  // Slot entry: holder, direction, inside flag, stamp.
  localparam int EntryW = 16 + 2 + 1 + 32;
  localparam logic [2:0] DirNone = 3'd4;

  typedef enum logic [2:0] {
    MODE_ACQ = 3'd0, MODE_ENTER = 3'd1, MODE_EXIT = 3'd2,
    MODE_REL = 3'd3, MODE_EXPIRE = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_GRANT = 4'd0, ST_REENTRY = 4'd1, ST_QUEUED = 4'd2, ST_TURN = 4'd3,
    ST_PASSED = 4'd4, ST_FULL = 4'd5, ST_ENTERED = 4'd6, ST_SKIP = 4'd7,
    ST_EXITED = 4'd8, ST_RELEASED = 4'd9, ST_EXPIRED = 4'd10
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_TURN = 2'd0, REG_MAX_AGE = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE, S_SCAN, S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] holder_id;
    logic [1:0]  direction;
    logic        direction_known;
    logic        already_passed;
    logic [31:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  status;
    logic        mark_passed;
    logic [2:0]  serving_dir;
    logic [7:0]  turn_count;
    logic        busy_res;
    logic [4:0]  expired_count;
  } out_item_t;
endpackage
`default_nettype wire

>>> rtl/core/idla_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module idla_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/intersection_direction_lock_arbiter.sv
// Top level of the direction lock arbiter: control, counters, waiting list.
// Depends on idla_pkg and idla_ram (holder table memory).
//
//  channel | signals                      | transfer
//  cmd     | start, busy, cmd             | start && !busy
//  result  | result_valid, result         | one cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_*  | cfg_valid && cfg_ready
//
// Each event scans the holder table one entry a cycle through the memory
// read port, and busy stays high through the scan and the final update.
// The result strobe comes in the first idle cycle after that, and the next
// event can be accepted there.
// The per-slot used bits live in flip-flops; reset clears them at once.
// Synchronous active-high reset; the receiver cannot stall results.
`default_nettype none
module intersection_direction_lock_arbiter (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire idla_pkg::in_item_t cmd,
  output logic                   result_valid,
  output idla_pkg::out_item_t    result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import idla_pkg::*;

  // Configuration registers.
  logic [7:0]  max_turn;
  logic [31:0] max_age;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_turn <= 8'd3;
      max_age  <= 32'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_TURN: max_turn <= cfg_data[7:0];
        REG_MAX_AGE:  max_age  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Architectural state outside the memory.
  logic [TableSlots-1:0] used;
  logic [CntW-1:0] pend [4];
  logic [CntW-1:0] ins [4];
  logic [2:0] serving;
  logic [7:0] turn;
  logic [1:0] wl [4];
  logic [2:0] wlen;

  // Scan control.
  fsm_t state, state_next;
  in_item_t it;
  logic [SlotW:0] idx;          // address issued
  logic [SlotW-1:0] ridx;       // address of data now on rdata
  logic rvalid;
  logic found;
  logic [SlotW-1:0] fslot;
  logic f_inside;
  logic [1:0] f_dir;
  logic have_free;
  logic [SlotW-1:0] free_s;
  logic [4:0] exp_cnt;

  // Memory.
  logic we;
  logic [SlotW-1:0] waddr;
  logic [EntryW-1:0] wdata, rdata;
  idla_ram #(.Width(EntryW), .Depth(TableSlots)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr(idx[SlotW-1:0]), .rdata
  );
  logic [15:0] r_holder;
  logic [1:0]  r_dir;
  logic        r_inside;
  logic [31:0] r_stamp;
  assign {r_holder, r_dir, r_inside, r_stamp} = rdata;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SCAN;
      S_SCAN: if (idx == (SlotW+1)'(TableSlots) && !rvalid) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Per-entry expiry test on the word just read.
  logic r_live, r_expire;
  assign r_live = rvalid && used[ridx];
  assign r_expire = r_live && !r_inside && ((it.now_tick - r_stamp) > max_age);

  // Helper values for the final update.
  logic any_b, dir_b;
  logic [1:0] d;
  always_comb begin
    any_b = 1'b0;
    for (int k = 0; k < 4; k++) any_b = any_b | (pend[k] != '0) | (ins[k] != '0);
    d = it.direction;
    dir_b = (pend[d] != '0) || (ins[d] != '0);
  end

  // Scan datapath and per-event update.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int k = 0; k < 4; k++) begin
        pend[k] <= '0;
        ins[k] <= '0;
        wl[k] <= 2'd0;
      end
      serving <= DirNone;
      turn <= 8'd0;
      wlen <= 3'd0;
      result_valid <= 1'b0;
      rvalid <= 1'b0;
      idx <= '0;
      we <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      we <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            it <= cmd;
            idx <= '0;
            rvalid <= 1'b0;
            found <= 1'b0;
            have_free <= 1'b0;
            exp_cnt <= 5'd0;
          end
        end
        S_SCAN: begin
          if (idx != (SlotW+1)'(TableSlots)) idx <= idx + 1'b1;
          rvalid <= (idx != (SlotW+1)'(TableSlots));
          ridx <= idx[SlotW-1:0];
          if (rvalid) begin
            if (!used[ridx] && !have_free) begin
              have_free <= 1'b1;
              free_s <= ridx;
            end
            if (r_live && r_holder == it.holder_id && !found) begin
              found <= 1'b1;
              fslot <= ridx;
              f_inside <= r_inside;
              f_dir <= r_dir;
            end
            // Expire drops entries during the scan itself.
            if (it.mode == MODE_EXPIRE && r_expire) begin
              used[ridx] <= 1'b0;
              if (pend[r_dir] != '0) pend[r_dir] <= pend[r_dir] - 1'b1;
              exp_cnt <= exp_cnt + 5'd1;
            end
          end
        end
        S_DONE: begin
          logic [3:0] st;
          logic mk;
          logic grant_ok;
          logic [2:0] sv;
          logic [7:0] tn;
          logic [CntW-1:0] p2 [4];
          logic [CntW-1:0] i2 [4];
          logic [1:0] w2 [4];
          logic [2:0] wl2;
          logic inl, ab;
          logic [2:0] j;
          st = ST_EXPIRED;
          mk = 1'b0;
          grant_ok = 1'b0;
          sv = serving;
          tn = turn;
          for (int k = 0; k < 4; k++) begin
            p2[k] = pend[k];
            i2[k] = ins[k];
            w2[k] = wl[k];
          end
          wl2 = wlen;
          inl = 1'b0;
          for (int k = 0; k < 4; k++)
            if (3'(k) < wlen && wl[k] == d) inl = 1'b1;
          case (it.mode) inside
            MODE_ACQ: begin
              if (!it.direction_known) st = ST_TURN;
              else if (it.already_passed) st = ST_PASSED;
              else if (found) st = ST_REENTRY;
              else if (!have_free) st = ST_FULL;
              else if (!any_b) begin
                if (wlen != 3'd0) begin
                  if ({1'b0, d} == serving) begin
                    tn = 8'd1;
                    grant_ok = 1'b1;
                  end else st = ST_QUEUED;
                end else begin
                  sv = {1'b0, d};
                  tn = 8'd1;
                  grant_ok = 1'b1;
                end
              end else if (serving == {1'b0, d} && turn < max_turn) begin
                tn = turn + 8'd1;
                grant_ok = 1'b1;
              end else if (dir_b) st = ST_TURN;
              else st = ST_QUEUED;
              if (st == ST_QUEUED && !grant_ok && !inl && wlen < 3'd4) begin
                w2[wlen[1:0]] = d;
                wl2 = wlen + 3'd1;
              end
              if (grant_ok) begin
                st = ST_GRANT;
                j = 3'd0;
                for (int k = 0; k < 4; k++) begin
                  if (3'(k) < wlen && wl[k] != d) begin
                    w2[j[1:0]] = wl[k];
                    j = j + 3'd1;
                  end
                end
                wl2 = j;
                p2[d] = pend[d] + 1'b1;
                used[free_s] <= 1'b1;
                we <= 1'b1;
                waddr <= free_s;
                wdata <= {it.holder_id, d, 1'b0, it.now_tick};
              end
            end
            MODE_ENTER: begin
              st = ST_ENTERED;
              if (found) begin
                if (!f_inside) begin
                  if (pend[f_dir] != '0) p2[f_dir] = pend[f_dir] - 1'b1;
                  i2[f_dir] = ins[f_dir] + 1'b1;
                  we <= 1'b1;
                  waddr <= fslot;
                  wdata <= {it.holder_id, f_dir, 1'b1, 32'd0};
                end
              end else if (!it.direction_known) st = ST_SKIP;
              else if (!have_free) st = ST_FULL;
              else begin
                i2[d] = ins[d] + 1'b1;
                used[free_s] <= 1'b1;
                we <= 1'b1;
                waddr <= free_s;
                wdata <= {it.holder_id, d, 1'b1, 32'd0};
              end
            end
            MODE_EXIT, MODE_REL: begin
              st = (it.mode == MODE_EXIT) ? ST_EXITED : ST_RELEASED;
              if (found) begin
                used[fslot] <= 1'b0;
                mk = 1'b1;
                if (f_inside) begin
                  if (ins[f_dir] != '0) i2[f_dir] = ins[f_dir] - 1'b1;
                end else if (pend[f_dir] != '0) p2[f_dir] = pend[f_dir] - 1'b1;
              end
              ab = 1'b0;
              for (int k = 0; k < 4; k++) ab = ab | (p2[k] != '0) | (i2[k] != '0);
              if (it.mode == MODE_EXIT && !ab) begin
                sv = (wlen != 3'd0) ? {1'b0, wl[0]} : DirNone;
                tn = 8'd0;
              end
              if (it.mode == MODE_REL) mk = 1'b0;
            end
            default: st = ST_EXPIRED;
          endcase
          ab = 1'b0;
          for (int k = 0; k < 4; k++) ab = ab | (p2[k] != '0) | (i2[k] != '0);
          for (int k = 0; k < 4; k++) begin
            pend[k] <= p2[k];
            ins[k] <= i2[k];
            wl[k] <= w2[k];
          end
          wlen <= wl2;
          serving <= sv;
          turn <= tn;
          result_valid <= (it.mode <= MODE_EXPIRE);
          result.granted <= (st <= ST_REENTRY);
          result.status <= st;
          result.mark_passed <= mk;
          result.serving_dir <= sv;
          result.turn_count <= tn;
          result.busy_res <= ab;
          result.expired_count <= (it.mode == MODE_EXPIRE) ? exp_cnt : 5'd0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/idla_checker.sv
// Port-level checker for the direction lock arbiter, bound to the top level.
// Depends on idla_pkg.
`default_nettype none
module idla_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                result_valid,
  input wire idla_pkg::out_item_t result
);
  import idla_pkg::*;

  // A result comes only at the end of an event.
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without event");
  // Accepted event makes the block busy next cycle.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("event not taken");
  // Granted matches status.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.granted == (result.status <= ST_REENTRY)))
    else $error("granted mismatch");
  // No serving direction means a zero turn count unless holders remain.
  a_none: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.serving_dir == DirNone |-> result.turn_count == 8'd0 ||
    result.busy_res) else $error("turn without serving direction");
endmodule

bind intersection_direction_lock_arbiter idla_checker u_idla_checker (
  .clk, .rst, .start, .busy, .result_valid, .result
);
`default_nettype wire
